/* design/firlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firlp_pkg
// Shared types, sizes and the hardwired coefficient table of the 32-tap
// symmetric low-pass filter.
// ----------------------------------------------------------------------------
package firlp_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int TAPS        = 32;
   localparam int PAIRS       = TAPS / 2;
   localparam int COEF_BITS   = 16;
   localparam int FRAC_BITS   = COEF_BITS - 1;

   // distributed arithmetic: pair sums split into groups of four address bits
   localparam int GROUP   = 4;
   localparam int GROUPS  = PAIRS / GROUP;
   localparam int GROUP_W = $clog2(GROUPS);

   // sum of all sixteen coefficients is 13573, fits 14 bits
   localparam int PART_W   = 14;
   // pre-added pair words are one bit wider than a sample
   localparam int STEPS    = SAMPLE_BITS + 1;
   localparam int STEP_W   = $clog2(STEPS);
   localparam int ACC_HI_W = PART_W + 4;
   localparam int Y_W      = ACC_HI_W + 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [STEP_W-1:0]             step_cnt_type;

   // control from the sequencer to the arithmetic unit
   typedef struct packed {
      logic advance;    // bit step 0 .. SAMPLE_BITS-1
      logic first;      // first bit step: clear carries and accumulator
      logic sign_step;  // sign bit step: partial sum weighs negative
   } step_type;

   // Q1.15 coefficients, first half; the second half mirrors it
   localparam logic [COEF_BITS-1:0] COEF [PAIRS] = '{
      16'd93,   16'd117,  16'd182,  16'd266,  16'd367,  16'd484,  16'd615,  16'd758,
      16'd906,  16'd1054, 16'd1198, 16'd1329, 16'd1443, 16'd1534, 16'd1597, 16'd1630
   };

   // sum of the coefficients of one group picked by the address bits
   function automatic logic [PART_W-1:0] da_lut(input logic [GROUP_W-1:0] grp,
                                               input logic [GROUP-1:0]   sel);
      logic [PART_W-1:0] sum;
      sum = '0;
      for (int j = 0; j < GROUP; j++) begin
         if (sel[j]) begin
            sum = sum + PART_W'(COEF[int'(grp) * GROUP + j]);
         end
      end
      return sum;
   endfunction

endpackage

/* design/firlp_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firlp_req_if / firlp_rsp_if
// Valid/ready channels carrying one sample word each.
// ----------------------------------------------------------------------------
interface firlp_req_if;
   import firlp_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface firlp_rsp_if;
   import firlp_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

/* design/fir_lowpass_32tap_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_lowpass_32tap_core
// 32-tap symmetric low-pass filter, Q1.15 in and out, bit-serial datapath.
//
//   channel   dir   handshake               word
//   req_chan  in    valid / ready           sample_in   signed 16 bit
//   rsp_chan  out   valid / ready           sample_out  signed 16 bit
//
// One word is taken when idle, then 17 bit steps run over the delay line
// (16 sample bits plus the sign bit of the pre-added pairs).
// The next word is accepted only after the previous result has moved into
// the output register, where it is held.
// Reset clears the delay line, the sequencer and the output valid.
// A result not yet taken holds the last bit step until the register frees.
// ----------------------------------------------------------------------------
module fir_lowpass_32tap_core (
   input  logic         clock,
   input  logic         reset,
   firlp_req_if.sink    req_chan,
   firlp_rsp_if.source  rsp_chan
);
   import firlp_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;
   localparam step_cnt_type LAST_STEP = step_cnt_type'(STEPS - 1);

   logic         state_ff, state_in;
   step_cnt_type cnt_ff, cnt_in;
   sample_type   dl_ff [TAPS];
   logic         rsp_valid_ff, rsp_valid_in;
   sample_type   rsp_data_ff, rsp_data_in;

   logic             req_fire;
   logic             out_free;
   logic             at_last;
   logic             commit;
   logic [TAPS-1:0]  tap_bits;
   step_type         ctrl;
   sample_type       result;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign at_last        = (state_ff == ST_BUSY) && (cnt_ff == LAST_STEP);
   assign commit         = at_last && out_free;

   assign ctrl.advance   = (state_ff == ST_BUSY) && (cnt_ff != LAST_STEP);
   assign ctrl.first     = (cnt_ff == '0);
   assign ctrl.sign_step = (cnt_ff == LAST_STEP);

   // index 0 holds the oldest sample; each word rotates right a bit per step,
   // so after the sample bits it is whole again and its msb is the sign
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         tap_bits[i] = ctrl.sign_step ? dl_ff[i][SAMPLE_BITS-1] : dl_ff[i][0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            dl_ff[i] <= '0;
         end
      end else if (req_fire) begin
         for (int i = 0; i < TAPS - 1; i++) begin
            dl_ff[i] <= dl_ff[i+1];
         end
         dl_ff[TAPS-1] <= req_chan.sample_in;
      end else if (ctrl.advance) begin
         for (int i = 0; i < TAPS; i++) begin
            dl_ff[i] <= {dl_ff[i][0], dl_ff[i][SAMPLE_BITS-1:1]};
         end
      end
   end

   firlp_da u_da (
      .clock    (clock),
      .ctrl     (ctrl),
      .tap_bits (tap_bits),
      .result   (result)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_BUSY;
               cnt_in   = '0;
            end
         end
         ST_BUSY: begin
            if (commit) begin
               state_in     = ST_IDLE;
               cnt_in       = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
            end else if (ctrl.advance) begin
               cnt_in = cnt_ff + step_cnt_type'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_data_ff;

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_BUSY) && (cnt_ff == '0))
      else $error("bit sequence did not start at step zero");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST_STEP)
      else $error("bit step counter out of range");

   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cnt_ff == '0))
      else $error("step counter not cleared while idle");

   a_commit_out: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished word not moved to the output register");

   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      (at_last && !out_free) |=> at_last)
      else $error("last bit step left while output register busy");

endmodule

/* design/firlp_da.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firlp_da
// Bit-serial pre-adders for the symmetric tap pairs, distributed arithmetic
// lookup and shift accumulator, with rounding and saturation of the result.
// ----------------------------------------------------------------------------
module firlp_da (
   input  logic                   clock,
   input  firlp_pkg::step_type    ctrl,
   input  logic [firlp_pkg::TAPS-1:0] tap_bits,
   output firlp_pkg::sample_type  result
);
   import firlp_pkg::*;

   localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(32'sd32767);
   localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-32'sd32768);
   localparam logic [SAMPLE_BITS:0]  HALF  = (SAMPLE_BITS+1)'(1) << (FRAC_BITS - 1);

   logic [PAIRS-1:0]           carry_ff, carry_in;
   logic [PAIRS-1:0]           pair_bits;
   logic signed [ACC_HI_W-1:0] hi_ff, hi_in;
   logic [SAMPLE_BITS-1:0]     lo_ff, lo_in;
   logic [PART_W-1:0]          part;
   logic signed [ACC_HI_W-1:0] part_ext;
   logic signed [ACC_HI_W-1:0] base;
   logic signed [ACC_HI_W-1:0] total;
   logic [SAMPLE_BITS:0]       lo_rnd;
   logic signed [Y_W-1:0]      y_full;

   // serial adders, one per mirrored pair, lsb first
   always_comb begin
      for (int k = 0; k < PAIRS; k++) begin
         logic a, b, c;
         a = tap_bits[k];
         b = tap_bits[TAPS-1-k];
         c = ctrl.first ? 1'b0 : carry_ff[k];
         pair_bits[k] = a ^ b ^ c;
         carry_in[k]  = (a & b) | (a & c) | (b & c);
      end
   end

   always_comb begin
      part = '0;
      for (int g = 0; g < GROUPS; g++) begin
         part = part + da_lut(GROUP_W'(g), pair_bits[g*GROUP +: GROUP]);
      end
   end

   assign part_ext = ACC_HI_W'(part);
   assign base     = ctrl.first ? '0 : hi_ff;
   assign total    = ctrl.sign_step ? (base - part_ext) : (base + part_ext);

   assign hi_in = total >>> 1;
   assign lo_in = {total[0], lo_ff[SAMPLE_BITS-1:1]};

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         carry_ff <= carry_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
      end
   end

   // accumulator = total * 2^16 + lo; round half up at bit 15, then clamp
   assign lo_rnd = {1'b0, lo_ff} + HALF;
   assign y_full = {total, 1'b0} + Y_W'(lo_rnd[SAMPLE_BITS:FRAC_BITS]);

   always_comb begin
      if (y_full > Y_MAX) begin
         result = sample_type'(Y_MAX);
      end else if (y_full < Y_MIN) begin
         result = sample_type'(Y_MIN);
      end else begin
         result = sample_type'(y_full);
      end
   end

endmodule

/* tb/tb_fir_lowpass_32tap_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_lowpass_32tap_core
// Self-checking bench for the 32-tap symmetric low-pass filter. A short table
// of directed samples runs first, then random signal segments (noise, held
// steps, full-scale or random-level alternation, ramps, near-zero values) in
// four idling phases. Outputs are checked against a model or typed-in values.
// ----------------------------------------------------------------------------
module tb_fir_lowpass_32tap_core;
   import firlp_pkg::*;

   localparam int CLOCK_HALF    = 2;
   localparam int RESET_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_WORDS   = 383;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 40;
   localparam int FILTER_TAPS   = 32;
   localparam int ROUND_SHIFT   = 15;

   // first half of the symmetric Q1.15 response, second half mirrors it
   localparam int LOWPASS_HALF [16] = '{
      93, 117, 182, 266, 367, 484, 615, 758,
      906, 1054, 1198, 1329, 1443, 1534, 1597, 1630
   };

   typedef struct packed {
      sample_type word;
      logic       pinned;
      sample_type out;
   } directed_row_type;

   typedef struct packed {
      logic       pinned;
      sample_type out;
   } typed_out_type;

   typedef enum {SEG_NOISE, SEG_STEP, SEG_ALTERNATE, SEG_RAMP, SEG_QUIET} segment_kind_type;

   // outputs typed in only where they follow at once from a cleared delay line
   localparam int DIRECTED_COUNT = 18;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{16'sd16384,  1'b1, 16'sd47},   // tie right after reset rounds up
      '{-16'sd16384, 1'b1, 16'sd12},
      '{16'sd32767,  1'b0, 16'sd0},
      '{-16'sd32768, 1'b0, 16'sd0},
      '{16'sd0,      1'b0, 16'sd0},
      '{16'sd1,      1'b0, 16'sd0},
      '{-16'sd1,     1'b0, 16'sd0},
      '{16'sd21845,  1'b0, 16'sd0},
      '{-16'sd21846, 1'b0, 16'sd0},
      '{16'sd255,    1'b0, 16'sd0},
      '{-16'sd256,   1'b0, 16'sd0},
      '{16'sd32767,  1'b0, 16'sd0},
      '{16'sd32767,  1'b0, 16'sd0},
      '{-16'sd32768, 1'b0, 16'sd0},
      '{-16'sd32768, 1'b0, 16'sd0},
      '{16'sd0,      1'b0, 16'sd0},
      '{16'sd1,      1'b0, 16'sd0},
      '{-16'sd2,     1'b0, 16'sd0}
   };

   logic clock;
   logic reset;

   firlp_req_if req_chan ();
   firlp_rsp_if rsp_chan ();

   fir_lowpass_32tap_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // filter model state
   sample_type hist_line [FILTER_TAPS];
   logic [4:0] hist_head;

   typed_out_type typed_out_q [$];
   sample_type pending_out_q [$];

   int send_idle_pct;
   int recv_stall_pct;
   int rsp_hold_cycles;
   int words_sent;
   int results_checked;
   int fail_count;
   int out_min;
   int out_max;
   int cycle_count;

   always begin
      clock = 1'b1;
      #CLOCK_HALF;
      clock = 1'b0;
      #CLOCK_HALF;
   end

   function automatic int lowpass_coef(input int k);
      return (k < 16) ? LOWPASS_HALF[k] : LOWPASS_HALF[31 - k];
   endfunction

   // writes one word into the delay line and returns the filtered output
   function automatic sample_type lowpass_predict(input sample_type word);
      longint acc;
      longint y;
      logic [4:0] k;
      hist_line[hist_head] = word;
      hist_head = hist_head + 5'd1;
      k = hist_head;
      acc = 0;
      // oldest sample meets the first coefficient
      for (int i = 0; i < FILTER_TAPS; i++) begin
         acc += longint'(lowpass_coef(i)) * longint'(hist_line[k]);
         k = k + 5'd1;
      end
      y = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (y > 32767) begin
         y = 32767;
      end
      if (y < -32768) begin
         y = -32768;
      end
      return sample_type'(y);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d outputs outstanding",
                  cycle_count, pending_out_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // word accepted: predict; word delivered: compare with the oldest prediction
   always @(posedge clock) begin : monitor
      typed_out_type pin;
      sample_type predicted;
      sample_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            pin = typed_out_q.pop_front();
            predicted = lowpass_predict(req_chan.sample_in);
            pending_out_q.push_back(pin.pinned ? pin.out : predicted);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_out_q.size() == 0) begin
               $error("sample_out: expected nothing, got %0d", rsp_chan.sample_out);
               fail_count++;
            end else begin
               want = pending_out_q.pop_front();
               if (rsp_chan.sample_out !== want) begin
                  $error("sample_out: expected %0d, got %0d", want, rsp_chan.sample_out);
                  fail_count++;
               end
               results_checked++;
               if (int'(rsp_chan.sample_out) < out_min) begin
                  out_min = int'(rsp_chan.sample_out);
               end
               if (int'(rsp_chan.sample_out) > out_max) begin
                  out_max = int'(rsp_chan.sample_out);
               end
            end
         end
      end
   end

   // output side: random stalls, or one long hold-off when asked
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // called at a rising edge; returns at the edge where the word is taken
   task automatic send_word(input sample_type word, input logic pinned,
                            input sample_type out);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      typed_out_q.push_back('{pinned, out});
      req_chan.valid     <= 1'b1;
      req_chan.sample_in <= word;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      words_sent++;
   endtask

   // always lets at least one edge pass so valid is never driven twice in a step
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_out_q.size() != 0);
   endtask

   task automatic play_segment(input segment_kind_type kind);
      int len;
      int level;
      int slope;
      logic full_scale;
      sample_type word;
      full_scale = 1'($urandom_range(1));
      level = $urandom_range(32767);
      slope = int'($urandom_range(2048)) - 1024;
      word = sample_type'($urandom);
      case (kind)
         SEG_STEP: begin
            len = $urandom_range(48, 32);
            case ($urandom_range(3))
               0: level = 32767;
               1: level = -32768;
               default: level = int'(sample_type'($urandom));
            endcase
         end
         SEG_ALTERNATE: len = $urandom_range(40, 32);
         SEG_RAMP:      len = $urandom_range(48, 16);
         SEG_QUIET:     len = $urandom_range(24, 8);
         default:       len = $urandom_range(40, 8);
      endcase
      for (int n = 0; n < len; n++) begin
         case (kind)
            SEG_STEP: word = sample_type'(level);
            SEG_ALTERNATE: begin
               if (full_scale) begin
                  word = n[0] ? 16'sh8000 : 16'sh7FFF;
               end else begin
                  word = sample_type'(n[0] ? -level : level);
               end
            end
            SEG_RAMP:  word = word + sample_type'(slope);
            SEG_QUIET: word = sample_type'(int'($urandom_range(8)) - 4);
            default:   word = sample_type'($urandom);
         endcase
         send_word(word, 1'b0, '0);
      end
   endtask

   initial begin
      int phase_start;
      logic hold_done;
      logic drain_done;
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.sample_in <= '0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      rsp_hold_cycles = 0;
      words_sent      = 0;
      results_checked = 0;
      fail_count      = 0;
      out_min         = 32767;
      out_max         = -32768;
      cycle_count     = 0;
      hist_head       = '0;
      hold_done       = 1'b0;
      drain_done      = 1'b0;
      for (int i = 0; i < FILTER_TAPS; i++) begin
         hist_line[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         send_word(DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].pinned, DIRECTED_ROWS[r].out);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            // output held off long enough that the filter backs up into its input
            if (phase == 0 && !hold_done && words_sent - phase_start >= 100) begin
               rsp_hold_cycles = HOLD_CYCLES;
               hold_done = 1'b1;
            end
            if (phase == 1 && !drain_done && words_sent - phase_start >= PHASE_WORDS / 2) begin
               wait_drained();
               drain_done = 1'b1;
            end
            play_segment(segment_kind_type'($urandom_range(4)));
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d words filtered (%0d directed), %0d outputs checked, span %0d..%0d",
               words_sent, DIRECTED_COUNT, results_checked, out_min, out_max);
      $display("summary: noise, held steps, alternation, ramps; four idling mixes, one long hold-off");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/firlp_pkg.sv
design/firlp_stream_if.sv
design/firlp_da.sv
design/fir_lowpass_32tap_core.sv
tb/tb_fir_lowpass_32tap_core.sv
